// ===== rtl/core/rcfh_pkg.sv =====
package rcfh_pkg;

  localparam int unsigned OriginW = 32;
  localparam int unsigned DirW    = 18;
  localparam int unsigned CenterW = 16;
  localparam int unsigned HalfW   = 15;
  localparam int unsigned ThrW    = 17;
  localparam int unsigned FracW   = 16;

  localparam int unsigned NumW    = 34;
  localparam int unsigned OffW    = 33;
  localparam int unsigned ProdMW  = OffW + DirW;
  localparam int unsigned ProdNW  = NumW + DirW;
  localparam int unsigned SumW    = ProdNW + 1;
  localparam int unsigned LimW    = HalfW + DirW;

  localparam logic [ThrW-1:0] ThrReset = ThrW'(7);

  typedef enum logic [2:0] {
    FACE_PZ   = 3'd0,
    FACE_NZ   = 3'd1,
    FACE_PY   = 3'd2,
    FACE_NY   = 3'd3,
    FACE_PX   = 3'd4,
    FACE_NX   = 3'd5,
    FACE_NONE = 3'd6
  } face_e;

endpackage

// ===== rtl/core/ray_cube_face_hit.sv =====
// Channel | Direction | Handshake                        | Payload
// item    | in        | start & !busy                    | ray origin/dir, cube center, half size
// config  | in        | cfg_valid_i & cfg_ready_o        | cfg_data_i (parallel threshold)
// result  | out       | result_valid_o, one cycle        | hit_o, hit_face_o
//
// One transaction enters per cycle; busy stays low.
// The result passes through the four-stage pipeline: offsets, products,
// sums and compares, face priority.
// Reset clears the valid bits and loads the threshold with 7.
// The receiver cannot stall, so valid bits simply advance every cycle.
module ray_cube_face_hit import rcfh_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [OriginW-1:0] ray_origin_x_i,
  input  logic signed [OriginW-1:0] ray_origin_y_i,
  input  logic signed [OriginW-1:0] ray_origin_z_i,
  input  logic signed [DirW-1:0]    ray_dir_x_i,
  input  logic signed [DirW-1:0]    ray_dir_y_i,
  input  logic signed [DirW-1:0]    ray_dir_z_i,
  input  logic signed [CenterW-1:0] cube_center_x_i,
  input  logic signed [CenterW-1:0] cube_center_y_i,
  input  logic signed [CenterW-1:0] cube_center_z_i,
  input  logic        [HalfW-1:0]   cube_half_size_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic        [ThrW-1:0]    cfg_data_i,
  output logic                      result_valid_o,
  output logic                      hit_o,
  output logic        [2:0]         hit_face_o
);

  logic [ThrW-1:0] thr_q;

  logic signed [OriginW-1:0] o   [3];
  logic signed [DirW-1:0]    d   [3];
  logic signed [CenterW-1:0] c   [3];

  logic                   v1_q, v2_q, v3_q, vo_q;
  logic signed [NumW-1:0] n_d  [6];
  logic signed [NumW-1:0] n_q  [6];
  logic signed [OffW-1:0] m_d  [3];
  logic signed [OffW-1:0] m_q  [3];
  logic signed [DirW-1:0] d_q  [3];
  logic [DirW-1:0]        ad_d [3];
  logic [DirW-1:0]        ad_q [3];
  logic [2:0]             par_d, par_q;
  logic [HalfW-1:0]       h_q;

  logic signed [ProdMW-1:0] p1_d [6][2];
  logic signed [ProdMW-1:0] p1_q [6][2];
  logic signed [ProdNW-1:0] p2_d [6][2];
  logic signed [ProdNW-1:0] p2_q [6][2];
  logic [LimW-1:0]          lim_d [3];
  logic [LimW-1:0]          lim_q [3];
  logic [5:0]               skip_d, skip_q;

  logic [5:0]  ok_d, ok_q;
  logic        hit_d, hit_q;
  face_e       face_d, face_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  assign o = '{ray_origin_x_i, ray_origin_y_i, ray_origin_z_i};
  assign d = '{ray_dir_x_i, ray_dir_y_i, ray_dir_z_i};
  assign c = '{cube_center_x_i, cube_center_y_i, cube_center_z_i};

  always_comb begin
    logic signed [CenterW:0] plane;
    int ax;
    plane = '0;
    ax    = 0;
    for (int a = 0; a < 3; a++) begin
      m_d[a]   = OffW'(o[a]) - (OffW'(c[a]) <<< FracW);
      ad_d[a]  = d[a][DirW-1] ? DirW'(-d[a]) : DirW'(d[a]);
      par_d[a] = (d[a] == '0) || (ad_d[a] < DirW'(thr_q));
    end
    for (int f = 0; f < 6; f++) begin
      ax = 2 - f / 2;
      if (f % 2 == 0) begin
        plane = (CenterW+1)'(c[ax]) + (CenterW+1)'(signed'({1'b0, cube_half_size_i}));
      end else begin
        plane = (CenterW+1)'(c[ax]) - (CenterW+1)'(signed'({1'b0, cube_half_size_i}));
      end
      n_d[f] = (NumW'(plane) <<< FracW) - NumW'(o[ax]);
    end
  end

  always_comb begin
    int ax;
    int b;
    ax = 0;
    b  = 0;
    for (int a = 0; a < 3; a++) begin
      lim_d[a] = LimW'(h_q) * LimW'(ad_q[a]);
    end
    for (int f = 0; f < 6; f++) begin
      ax = 2 - f / 2;
      skip_d[f] = par_q[ax]
               || (n_q[f][NumW-1] && !d_q[ax][DirW-1])
               || (!n_q[f][NumW-1] && (n_q[f] != '0) && d_q[ax][DirW-1]);
      for (int j = 0; j < 2; j++) begin
        b = (ax + j + 1) % 3;
        p1_d[f][j] = ProdMW'(m_q[b]) * ProdMW'(d_q[ax]);
        p2_d[f][j] = ProdNW'(d_q[b]) * ProdNW'(n_q[f]);
      end
    end
  end

  always_comb begin
    logic signed [SumW-1:0] s;
    logic [SumW-1:0]        mag;
    logic [SumW-1:0]        lim;
    logic                   ok;
    int ax;
    s   = '0;
    mag = '0;
    lim = '0;
    ok  = 1'b0;
    ax  = 0;
    for (int f = 0; f < 6; f++) begin
      ax  = 2 - f / 2;
      lim = SumW'(lim_q[ax]) << FracW;
      ok  = !skip_q[f];
      for (int j = 0; j < 2; j++) begin
        s   = SumW'(p1_q[f][j]) + SumW'(p2_q[f][j]);
        mag = s[SumW-1] ? SumW'(-s) : SumW'(s);
        ok  = ok && (mag < lim);
      end
      ok_d[f] = ok;
    end
  end

  always_comb begin
    hit_d  = |ok_q;
    face_d = FACE_NONE;
    for (int f = 5; f >= 0; f--) begin
      if (ok_q[f]) begin
        face_d = face_e'(3'(f));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      vo_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        thr_q <= cfg_data_i;
      end
      v1_q <= start && !busy;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    m_q    <= m_d;
    d_q    <= d;
    ad_q   <= ad_d;
    par_q  <= par_d;
    h_q    <= cube_half_size_i;
    p1_q   <= p1_d;
    p2_q   <= p2_d;
    lim_q  <= lim_d;
    skip_q <= skip_d;
    ok_q   <= ok_d;
    hit_q  <= hit_d;
    face_q <= face_d;
  end

  assign result_valid_o = vo_q;
  assign hit_o          = hit_q;
  assign hit_face_o     = face_q;

  a_hit_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (hit_o == (hit_face_o != FACE_NONE)))
    else $error("hit flag disagrees with face code");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##4 result_valid_o)
    else $error("result missing four cycles after transaction");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> $past(v1_q, 2))
    else $error("valid bit appeared without a transaction");

  a_zero_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && $past(h_q) == '0) |=> (ok_q == '0))
    else $error("face hit with zero half size");

endmodule
